@@ hw/rtl/aqt_pkg.sv @@
// aqt_pkg.sv: shared types, codes and the transition rule for the lifecycle quota tracker
`timescale 1ns / 1ps

package aqt_pkg;

    localparam int unsigned NumKinds  = 5;
    localparam int unsigned CountW    = 32;
    localparam int unsigned CfgIndexW = 3;

    // command codes
    typedef enum logic [2:0] {
        ACT_START      = 3'd0,
        ACT_TRANSITION = 3'd1,
        ACT_CLOSE      = 3'd2,
        ACT_EXIT       = 3'd3,
        ACT_CLEANUP    = 3'd4,
        ACT_RESERVE    = 3'd5,
        ACT_RELEASE    = 3'd6,
        ACT_HIGH_WATER = 3'd7
    } action_t;

    // lifecycle phases
    typedef enum logic [2:0] {
        PH_STARTING = 3'd0,
        PH_RUNNING  = 3'd1,
        PH_WAITING  = 3'd2,
        PH_CLOSING  = 3'd3,
        PH_EXITED   = 3'd4,
        PH_CLEANED  = 3'd5
    } phase_t;

    // configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_Q_WINDOWS    = 3'd0,
        CFG_Q_WIDGETS    = 3'd1,
        CFG_Q_MAPPED     = 3'd2,
        CFG_Q_STACK      = 3'd3,
        CFG_Q_STRING     = 3'd4,
        CFG_Q_EVENTS     = 3'd5,
        CFG_RUNTIME      = 3'd6,
        CFG_GENERATION   = 3'd7
    } cfg_index_t;

    typedef logic [CountW-1:0] count_t;

    // tracker state
    typedef struct packed {
        logic [2:0]                 phase;
        logic [NumKinds-1:0][CountW-1:0] used;
        count_t                     peak;
    } track_state_t;

    // configuration seen by the engine
    typedef struct packed {
        logic [NumKinds-1:0][CountW-1:0] quota;
        count_t                     quota_events;
        logic [7:0]                 runtime;
        logic [15:0]                generation;
    } track_cfg_t;

    // one command word
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  target_state;
        logic [2:0]  resource_kind;
        count_t      amount;
    } cmd_t;

    // one result word
    typedef struct packed {
        logic        ok;
        logic [2:0]  lifecycle_state;
        count_t      used_count;
        count_t      high_water;
    } result_t;

    // allowed lifecycle moves
    function automatic logic move_allowed(input logic [2:0] from_ph, input logic [2:0] to_ph);
        logic allowed;
        allowed = 1'b0;
        case (from_ph)
            PH_STARTING: allowed = (to_ph == PH_RUNNING) || (to_ph == PH_CLOSING);
            PH_RUNNING:  allowed = (to_ph == PH_WAITING) || (to_ph == PH_CLOSING)
                                   || (to_ph == PH_EXITED);
            PH_WAITING:  allowed = (to_ph == PH_RUNNING) || (to_ph == PH_CLOSING)
                                   || (to_ph == PH_EXITED);
            PH_CLOSING:  allowed = (to_ph == PH_EXITED);
            PH_EXITED:   allowed = (to_ph == PH_CLEANED);
            default:     allowed = 1'b0;
        endcase
        return allowed;
    endfunction

endpackage

@@ hw/rtl/app_lifecycle_quota_tracker.sv @@
// app_lifecycle_quota_tracker.sv: top level with config registers, state and word pipeline
`timescale 1ns / 1ps

// Tracks one application's lifecycle phase, five resource use counters and a peak
// event level. Each accepted command word gives exactly one result word. A command
// is captured in an input register, executed by a single pass of compare and add logic
// against the tracker state, and its result lands in an output register; one command
// is taken every cycle while the output side keeps up. Stall on the input side follows
// the output stall whenever both registers are full. Quota registers are read live;
// write them only while the block is idle. Reset puts the phase at cleaned and clears
// every counter.

module app_lifecycle_quota_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // command side
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  target_state,
    input  logic [2:0]  resource_kind,
    input  logic [31:0] amount,
    // result side
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [2:0]  lifecycle_state,
    output logic [31:0] used_count,
    output logic [31:0] high_water
);

    aqt_pkg::track_cfg_t   cfg_reg;
    aqt_pkg::track_state_t st_reg;
    aqt_pkg::track_state_t st_next;
    aqt_pkg::cmd_t         cmd_reg;
    logic                  cmd_valid_reg;
    aqt_pkg::result_t      res_reg;
    aqt_pkg::result_t      res_next;
    logic                  res_valid_reg;
    logic                  res_load;
    logic                  cmd_load;

    // handshake
    assign res_load = cmd_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = cmd_valid_reg && !res_load;
    assign cmd_load = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (aqt_pkg::cfg_index_t'(cfg_index))
                aqt_pkg::CFG_Q_WINDOWS:  cfg_reg.quota[0]     <= cfg_data;
                aqt_pkg::CFG_Q_WIDGETS:  cfg_reg.quota[1]     <= cfg_data;
                aqt_pkg::CFG_Q_MAPPED:   cfg_reg.quota[2]     <= cfg_data;
                aqt_pkg::CFG_Q_STACK:    cfg_reg.quota[3]     <= cfg_data;
                aqt_pkg::CFG_Q_STRING:   cfg_reg.quota[4]     <= cfg_data;
                aqt_pkg::CFG_Q_EVENTS:   cfg_reg.quota_events <= cfg_data;
                aqt_pkg::CFG_RUNTIME:    cfg_reg.runtime      <= cfg_data[7:0];
                aqt_pkg::CFG_GENERATION: cfg_reg.generation   <= cfg_data[15:0];
                default:                 cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_load || res_load)
        begin
            cmd_valid_reg <= cmd_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg.action        <= action;
            cmd_reg.target_state  <= target_state;
            cmd_reg.resource_kind <= resource_kind;
            cmd_reg.amount        <= amount;
        end
    end

    // command engine
    aqt_exec u_exec
    (
        .cmd (cmd_reg),
        .cur (st_reg),
        .cfg (cfg_reg),
        .nxt (st_next),
        .res (res_next)
    );

    // tracker state, updated as each word is executed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase <= aqt_pkg::PH_CLEANED;
            st_reg.used  <= '0;
            st_reg.peak  <= '0;
        end
        else if (res_load)
        begin
            st_reg <= st_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign ok              = res_reg.ok;
    assign lifecycle_state = res_reg.lifecycle_state;
    assign used_count      = res_reg.used_count;
    assign high_water      = res_reg.high_water;

endmodule

@@ hw/rtl/aqt_exec.sv @@
// aqt_exec.sv: combinational command engine, next tracker state and result word
`timescale 1ns / 1ps

module aqt_exec
(
    input  aqt_pkg::cmd_t         cmd,
    input  aqt_pkg::track_state_t cur,
    input  aqt_pkg::track_cfg_t   cfg,
    output aqt_pkg::track_state_t nxt,
    output aqt_pkg::result_t      res
);

    logic                 kind_ok;
    logic [2:0]           kidx;
    aqt_pkg::count_t      quota;
    aqt_pkg::count_t      used;
    aqt_pkg::count_t      room;
    aqt_pkg::count_t      sum;
    logic                 start_ok;
    logic                 ok;
    logic                 run_ok;

    // selected resource and its quota
    always_comb
    begin
        kind_ok = (cmd.resource_kind < 3'(aqt_pkg::NumKinds));
        kidx    = kind_ok ? cmd.resource_kind : 3'd0;
        quota   = cfg.quota[kidx];
        used    = cur.used[kidx];
        room    = quota - ((used <= quota) ? used : quota);
        sum     = used + cmd.amount;
        run_ok  = (cur.phase == aqt_pkg::PH_STARTING) || (cur.phase == aqt_pkg::PH_RUNNING);
        start_ok = (cfg.runtime != 8'd0) && (cfg.generation != 16'd0)
                   && (cfg.quota[0] != '0) && (cfg.quota[1] != '0)
                   && (cfg.quota[2] != '0) && (cfg.quota[3] != '0)
                   && (cfg.quota_events != '0);
    end

    // command decode and state update
    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        case (aqt_pkg::action_t'(cmd.action))
            aqt_pkg::ACT_START:
            begin
                if (start_ok)
                begin
                    nxt.phase = aqt_pkg::PH_STARTING;
                    nxt.used  = '0;
                    nxt.peak  = '0;
                    ok        = 1'b1;
                end
            end
            aqt_pkg::ACT_TRANSITION:
            begin
                if (aqt_pkg::move_allowed(cur.phase, cmd.target_state))
                begin
                    nxt.phase = cmd.target_state;
                    ok        = 1'b1;
                end
            end
            aqt_pkg::ACT_CLOSE:
            begin
                if (cur.phase == aqt_pkg::PH_CLOSING)
                    ok = 1'b1;
                else if (cur.phase == aqt_pkg::PH_STARTING || cur.phase == aqt_pkg::PH_RUNNING
                         || cur.phase == aqt_pkg::PH_WAITING)
                begin
                    nxt.phase = aqt_pkg::PH_CLOSING;
                    ok        = 1'b1;
                end
            end
            aqt_pkg::ACT_EXIT:
            begin
                if (cur.phase == aqt_pkg::PH_EXITED)
                    ok = 1'b1;
                else if (cur.phase == aqt_pkg::PH_CLOSING || cur.phase == aqt_pkg::PH_RUNNING
                         || cur.phase == aqt_pkg::PH_WAITING)
                begin
                    nxt.phase = aqt_pkg::PH_EXITED;
                    ok        = 1'b1;
                end
            end
            aqt_pkg::ACT_CLEANUP:
            begin
                if (cur.phase == aqt_pkg::PH_CLEANED)
                    ok = 1'b1;
                else if (cur.phase == aqt_pkg::PH_EXITED)
                begin
                    nxt.phase = aqt_pkg::PH_CLEANED;
                    nxt.used  = '0;
                    nxt.peak  = '0;
                    ok        = 1'b1;
                end
            end
            aqt_pkg::ACT_RESERVE:
            begin
                if (kind_ok && run_ok && (cmd.amount <= room))
                begin
                    nxt.used[kidx] = sum;
                    ok             = 1'b1;
                end
            end
            aqt_pkg::ACT_RELEASE:
            begin
                if (kind_ok)
                begin
                    nxt.used[kidx] = (cmd.amount >= used) ? '0 : (used - cmd.amount);
                    ok             = 1'b1;
                end
            end
            aqt_pkg::ACT_HIGH_WATER:
            begin
                if (cmd.amount > cur.peak)
                    nxt.peak = cmd.amount;
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // result word after the command
    always_comb
    begin
        res.ok              = ok;
        res.lifecycle_state = nxt.phase;
        res.used_count      = kind_ok ? nxt.used[kidx] : '0;
        res.high_water      = nxt.peak;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top.sv: self-checking testbench for the application lifecycle and quota tracker
`timescale 1ns / 1ps

module tb_top;

    localparam int LongHold   = 64;
    localparam int PhaseItems = 200;
    localparam int NumPhases  = 8;

    // clock, reset and block inputs, all known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic [2:0]  action        = '0;
    logic [2:0]  target_state  = '0;
    logic [2:0]  resource_kind = '0;
    logic [31:0] amount        = '0;
    logic        out_stall     = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic        ok;
    logic [2:0]  lifecycle_state;
    logic [31:0] used_count;
    logic [31:0] high_water;

    app_lifecycle_quota_tracker u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .target_state    (target_state),
        .resource_kind   (resource_kind),
        .amount          (amount),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .lifecycle_state (lifecycle_state),
        .used_count      (used_count),
        .high_water      (high_water)
    );

    // tracker copy: register values and state after reset
    logic [31:0] cfg_quota [aqt_pkg::NumKinds] = '{default: '0};
    logic [31:0] cfg_q_events   = '0;
    logic [7:0]  cfg_runtime    = '0;
    logic [15:0] cfg_generation = '0;
    logic [2:0]  trk_phase = aqt_pkg::PH_CLEANED;
    logic [31:0] trk_used [aqt_pkg::NumKinds] = '{default: '0};
    logic [31:0] trk_peak = '0;

    aqt_pkg::cmd_t    queued_cmds [$];
    aqt_pkg::result_t due_replies [$];
    aqt_pkg::cmd_t    drv_cmd;
    int      drv_gap     = 0;
    logic    drv_burst   = 1'b0;
    int      rx_wait     = 0;
    logic    rx_burst    = 1'b0;
    int      replies_seen = 0;
    int      queued_total = 0;
    int      error_count  = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // lifecycle moves as a set of reachable phases per phase
    function automatic logic legal_move(logic [2:0] from_ph, logic [2:0] to_ph);
        logic [7:0] reach;
        reach = '0;
        case (from_ph)
            aqt_pkg::PH_STARTING: reach = 8'(1 << aqt_pkg::PH_RUNNING)
                                          | 8'(1 << aqt_pkg::PH_CLOSING);
            aqt_pkg::PH_RUNNING:  reach = 8'(1 << aqt_pkg::PH_WAITING)
                                          | 8'(1 << aqt_pkg::PH_CLOSING)
                                          | 8'(1 << aqt_pkg::PH_EXITED);
            aqt_pkg::PH_WAITING:  reach = 8'(1 << aqt_pkg::PH_RUNNING)
                                          | 8'(1 << aqt_pkg::PH_CLOSING)
                                          | 8'(1 << aqt_pkg::PH_EXITED);
            aqt_pkg::PH_CLOSING:  reach = 8'(1 << aqt_pkg::PH_EXITED);
            aqt_pkg::PH_EXITED:   reach = 8'(1 << aqt_pkg::PH_CLEANED);
            default:              reach = '0;
        endcase
        return reach[to_ph];
    endfunction

    function automatic void clear_counters();
        foreach (trk_used[k]) trk_used[k] = '0;
        trk_peak = '0;
    endfunction

    // runs one command on the tracker copy and gives the reply word it causes
    function automatic aqt_pkg::result_t apply_command(aqt_pkg::cmd_t c);
        aqt_pkg::result_t r;
        logic        kind_ok;
        logic [31:0] quota;
        logic [31:0] used;
        logic [31:0] room;
        kind_ok = c.resource_kind < aqt_pkg::NumKinds;
        r.ok    = 1'b0;
        case (aqt_pkg::action_t'(c.action))
            aqt_pkg::ACT_START:
                if (cfg_runtime != 0 && cfg_generation != 0 && cfg_q_events != 0
                    && cfg_quota[0] != 0 && cfg_quota[1] != 0
                    && cfg_quota[2] != 0 && cfg_quota[3] != 0)
                begin
                    trk_phase = aqt_pkg::PH_STARTING;
                    clear_counters();
                    r.ok = 1'b1;
                end
            aqt_pkg::ACT_TRANSITION:
                if (legal_move(trk_phase, c.target_state))
                begin
                    trk_phase = c.target_state;
                    r.ok = 1'b1;
                end
            aqt_pkg::ACT_CLOSE:
                if (trk_phase == aqt_pkg::PH_CLOSING)
                    r.ok = 1'b1;
                else if (trk_phase inside {aqt_pkg::PH_STARTING, aqt_pkg::PH_RUNNING,
                                           aqt_pkg::PH_WAITING})
                begin
                    trk_phase = aqt_pkg::PH_CLOSING;
                    r.ok = 1'b1;
                end
            aqt_pkg::ACT_EXIT:
                if (trk_phase == aqt_pkg::PH_EXITED)
                    r.ok = 1'b1;
                else if (trk_phase inside {aqt_pkg::PH_CLOSING, aqt_pkg::PH_RUNNING,
                                           aqt_pkg::PH_WAITING})
                begin
                    trk_phase = aqt_pkg::PH_EXITED;
                    r.ok = 1'b1;
                end
            aqt_pkg::ACT_CLEANUP:
                if (trk_phase == aqt_pkg::PH_CLEANED)
                    r.ok = 1'b1;
                else if (trk_phase == aqt_pkg::PH_EXITED)
                begin
                    clear_counters();
                    trk_phase = aqt_pkg::PH_CLEANED;
                    r.ok = 1'b1;
                end
            aqt_pkg::ACT_RESERVE:
                if (kind_ok && (trk_phase == aqt_pkg::PH_STARTING
                                || trk_phase == aqt_pkg::PH_RUNNING))
                begin
                    quota = cfg_quota[c.resource_kind];
                    used  = trk_used[c.resource_kind];
                    // a count above the quota leaves no room at all
                    room  = quota - ((used <= quota) ? used : quota);
                    if (c.amount <= room)
                    begin
                        trk_used[c.resource_kind] = used + c.amount;
                        r.ok = 1'b1;
                    end
                end
            aqt_pkg::ACT_RELEASE:
                if (kind_ok)
                begin
                    used = trk_used[c.resource_kind];
                    trk_used[c.resource_kind] = (c.amount >= used) ? '0 : used - c.amount;
                    r.ok = 1'b1;
                end
            default:
            begin
                if (c.amount > trk_peak) trk_peak = c.amount;
                r.ok = 1'b1;
            end
        endcase
        r.lifecycle_state = trk_phase;
        r.used_count      = kind_ok ? trk_used[c.resource_kind] : '0;
        r.high_water      = trk_peak;
        return r;
    endfunction

    function automatic int draw_wait(logic burst);
        return burst ? 0 : int'($urandom_range(0, 7));
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                due_replies.push_back(apply_command(drv_cmd));
            if (!in_valid || !in_stall)
            begin
                if (drv_gap > 0 || queued_cmds.size() == 0)
                begin
                    if (drv_gap > 0) drv_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    drv_cmd = queued_cmds.pop_front();
                    if ($urandom_range(0, 39) == 0) drv_burst = ~drv_burst;
                    drv_gap = draw_wait(drv_burst);
                    in_valid      <= 1'b1;
                    action        <= drv_cmd.action;
                    target_state  <= drv_cmd.target_state;
                    resource_kind <= drv_cmd.resource_kind;
                    amount        <= drv_cmd.amount;
                end
            end
        end
    end

    // reply monitor and receiver stall
    always @(posedge clk)
    begin : watch
        aqt_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_replies.size() == 0)
                begin
                    $error("reply word with no command outstanding");
                    error_count++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, ok);
                        error_count++;
                    end
                    if (lifecycle_state !== want.lifecycle_state)
                    begin
                        $error("lifecycle_state: expected %0d, got %0d",
                               want.lifecycle_state, lifecycle_state);
                        error_count++;
                    end
                    if (used_count !== want.used_count)
                    begin
                        $error("used_count: expected %0h, got %0h", want.used_count, used_count);
                        error_count++;
                    end
                    if (high_water !== want.high_water)
                    begin
                        $error("high_water: expected %0h, got %0h", want.high_water, high_water);
                        error_count++;
                    end
                end
                replies_seen++;
                if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
                // long hold-offs let the block fill and push back on commands
                if (replies_seen == 300 || replies_seen == 1000)
                    rx_wait = LongHold;
                else
                    rx_wait = draw_wait(rx_burst);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_cmd(aqt_pkg::action_t a, logic [2:0] tgt, logic [2:0] kind,
                            logic [31:0] amt);
        aqt_pkg::cmd_t c;
        c.action        = a;
        c.target_state  = tgt;
        c.resource_kind = kind;
        c.amount        = amt;
        queued_cmds.push_back(c);
        queued_total++;
    endtask

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [2:0] rand_kind();
        if ($urandom_range(0, 9) == 0) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    function automatic logic [31:0] rand_reg(logic hostile);
        case ($urandom_range(0, 7))
            0:       return hostile ? 32'd0 : 32'd1;
            1:       return '1;
            2, 3, 4: return $urandom_range(1, 6);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_noise();
        push_cmd(aqt_pkg::action_t'(3'($urandom)), 3'($urandom), 3'($urandom), $urandom);
    endtask

    // one lifecycle: start, some resource traffic, then usually a way out
    task automatic add_session();
        int n;
        push_cmd(aqt_pkg::ACT_START, 3'($urandom), rand_kind(), $urandom);
        if ($urandom_range(0, 2) != 0)
            push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_RUNNING, rand_kind(), '0);
        n = $urandom_range(3, 14);
        repeat (n)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4: push_cmd(aqt_pkg::ACT_RESERVE, 3'($urandom), rand_kind(),
                                        rand_amount());
                5, 6:          push_cmd(aqt_pkg::ACT_RELEASE, 3'($urandom), rand_kind(),
                                        rand_amount());
                7:             push_cmd(aqt_pkg::ACT_HIGH_WATER, 3'($urandom), rand_kind(),
                                        $urandom_range(0, 1) ? $urandom : rand_amount());
                8:             push_cmd(aqt_pkg::ACT_TRANSITION, 3'($urandom_range(0, 5)),
                                        rand_kind(), $urandom);
                9:             push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_RUNNING,
                                        rand_kind(), '0);
                default:       push_noise();
            endcase
        end
        case ($urandom_range(0, 4))
            0: ;
            1:
            begin
                push_cmd(aqt_pkg::ACT_CLOSE, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_EXIT, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_CLEANUP, 3'($urandom), rand_kind(), $urandom);
            end
            2:
            begin
                push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_CLOSING, rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_EXITED, rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_CLEANED, rand_kind(), $urandom);
            end
            3:
            begin
                push_cmd(aqt_pkg::ACT_EXIT, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_CLEANUP, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_CLEANUP, 3'($urandom), rand_kind(), $urandom);
            end
            default:
            begin
                push_cmd(aqt_pkg::ACT_CLOSE, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_CLOSE, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_EXIT, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_EXIT, 3'($urandom), rand_kind(), $urandom);
                push_cmd(aqt_pkg::ACT_CLEANUP, 3'($urandom), rand_kind(), $urandom);
            end
        endcase
    endtask

    function automatic void note_register(aqt_pkg::cfg_index_t idx, logic [31:0] v);
        case (idx)
            aqt_pkg::CFG_Q_WINDOWS:  cfg_quota[0]   = v;
            aqt_pkg::CFG_Q_WIDGETS:  cfg_quota[1]   = v;
            aqt_pkg::CFG_Q_MAPPED:   cfg_quota[2]   = v;
            aqt_pkg::CFG_Q_STACK:    cfg_quota[3]   = v;
            aqt_pkg::CFG_Q_STRING:   cfg_quota[4]   = v;
            aqt_pkg::CFG_Q_EVENTS:   cfg_q_events   = v;
            aqt_pkg::CFG_RUNTIME:    cfg_runtime    = v[7:0];
            aqt_pkg::CFG_GENERATION: cfg_generation = v[15:0];
            default: ;
        endcase
    endfunction

    // writes every register, one per cycle
    task automatic load_config(input logic [31:0] regs [8]);
        aqt_pkg::cfg_index_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= regs[idx];
            note_register(idx, regs[idx]);
            idx = idx.next();
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds back until every reply is in and the pipeline has drained
    task automatic wait_idle();
        do @(negedge clk);
        while (queued_cmds.size() != 0 || in_valid || due_replies.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] regs [8];
        int          ph;
        int          phase_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: start must fail
        push_cmd(aqt_pkg::ACT_START, aqt_pkg::PH_STARTING, 3'd0, '0);
        push_cmd(aqt_pkg::ACT_CLEANUP, aqt_pkg::PH_STARTING, 3'd0, '0);
        push_cmd(aqt_pkg::ACT_HIGH_WATER, aqt_pkg::PH_STARTING, 3'd0, 32'd5);
        wait_idle();

        regs[aqt_pkg::CFG_Q_WINDOWS]  = 32'd1;
        regs[aqt_pkg::CFG_Q_WIDGETS]  = '1;
        regs[aqt_pkg::CFG_Q_MAPPED]   = 32'd3;
        regs[aqt_pkg::CFG_Q_STACK]    = 32'd2;
        regs[aqt_pkg::CFG_Q_STRING]   = '0;
        regs[aqt_pkg::CFG_Q_EVENTS]   = 32'd1;
        regs[aqt_pkg::CFG_RUNTIME]    = '1;
        regs[aqt_pkg::CFG_GENERATION] = 32'h0000_FFFF;
        load_config(regs);

        // quota edges, unknown kinds, release floor and every lifecycle command
        push_cmd(aqt_pkg::ACT_START, 3'd7, 3'd7, '1);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd0, 32'd1);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd0, 32'd1);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd1, '1);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd4, '0);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd4, 32'd1);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd5, '0);
        push_cmd(aqt_pkg::ACT_RELEASE, aqt_pkg::PH_STARTING, 3'd7, '0);
        push_cmd(aqt_pkg::ACT_RELEASE, aqt_pkg::PH_STARTING, 3'd1, 32'd5);
        push_cmd(aqt_pkg::ACT_RELEASE, aqt_pkg::PH_STARTING, 3'd2, '1);
        push_cmd(aqt_pkg::ACT_HIGH_WATER, aqt_pkg::PH_STARTING, 3'd1, '1);
        push_cmd(aqt_pkg::ACT_TRANSITION, 3'd7, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_RUNNING, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_WAITING, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_RESERVE, aqt_pkg::PH_STARTING, 3'd3, 32'd1);
        push_cmd(aqt_pkg::ACT_CLOSE, aqt_pkg::PH_STARTING, 3'd3, '0);
        push_cmd(aqt_pkg::ACT_CLOSE, aqt_pkg::PH_STARTING, 3'd3, '0);
        push_cmd(aqt_pkg::ACT_EXIT, aqt_pkg::PH_STARTING, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_EXIT, aqt_pkg::PH_STARTING, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_TRANSITION, aqt_pkg::PH_CLEANED, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_CLEANUP, aqt_pkg::PH_STARTING, 3'd1, '0);
        push_cmd(aqt_pkg::ACT_START, aqt_pkg::PH_STARTING, 3'd1, '0);
        wait_idle();

        for (ph = 0; ph < NumPhases; ph++)
        begin
            // first all registers at their top, then the smallest that still start, then random ones
            foreach (regs[i]) regs[i] = (ph == 0) ? '1 : rand_reg(ph % 3 == 2);
            if (ph == 1)
            begin
                foreach (regs[i]) regs[i] = 32'd1;
                regs[aqt_pkg::CFG_Q_STRING] = '0;
            end
            load_config(regs);
            phase_start = queued_total;
            // leftover counts may now sit above the new quotas
            repeat (4)
            begin
                case ($urandom_range(0, 2))
                    0: push_cmd(aqt_pkg::ACT_RESERVE, 3'($urandom), rand_kind(),
                                $urandom_range(0, 1) ? '0 : rand_amount());
                    1: push_cmd(aqt_pkg::ACT_RELEASE, 3'($urandom), rand_kind(),
                                rand_amount());
                    default: push_noise();
                endcase
            end
            while (queued_total - phase_start < PhaseItems)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_noise();
                else
                    add_session();
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS app_lifecycle_quota_tracker");
        else
            $display("FAIL app_lifecycle_quota_tracker");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("FAIL app_lifecycle_quota_tracker");
        $finish;
    end

endmodule
